>>> hw/rtl/rwm_pkg.sv
// shared constants, codes and control types for the raster window statistic
`timescale 1ns / 1ps
`default_nettype none
package rwm_pkg;
	localparam int MAX_WIDTH    = 1024;
	localparam int COL_BITS     = $clog2(MAX_WIDTH);
	localparam int WIDTH_BITS   = COL_BITS + 1;
	localparam int MAX_RADIUS   = 7;
	localparam int RAD_BITS     = 3;
	localparam int STORE_ROWS   = 2 * MAX_RADIUS + 1;
	localparam int SROW_BITS    = $clog2(STORE_ROWS);
	localparam int STORE_DEPTH  = STORE_ROWS * MAX_WIDTH;
	localparam int ADDR_BITS    = SROW_BITS + COL_BITS;
	localparam int SAMPLE_BITS  = 16;
	localparam int ROW_BITS     = 16;
	localparam int POS_ROW_BITS = ROW_BITS + 1;
	localparam int WIN_CELLS    = STORE_ROWS * STORE_ROWS;
	localparam int CNT_BITS     = $clog2(WIN_CELLS + 1);
	localparam int ACC_BITS     = SAMPLE_BITS + CNT_BITS;
	localparam int MODE_BITS    = 2;
	localparam int IDX_BITS     = 2;
	localparam int CFG_BITS     = 16;

	localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_MIN = 2'd2;

	localparam logic [IDX_BITS-1:0] REG_MODE   = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_WIDTH  = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_HEIGHT = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_RADIUS = 2'd3;

	typedef struct packed {
		logic accept;
		logic setup;
		logic win_init;
		logic scan;
		logic div_start;
		logic load_out;
		logic next_col;
		logic pos_update;
	} cmd_t;

	typedef struct packed {
		logic ignore;
		logic has_out;
		logic scan_last;
		logic is_mean;
		logic div_done;
		logic out_free;
		logic res_last;
	} status_t;
endpackage
`default_nettype wire

>>> hw/rtl/rwm_in_if.sv
// input channel: pixel or drain beats
`timescale 1ns / 1ps
`default_nettype none
interface rwm_in_if
	import rwm_pkg::*;
	();
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic signed [SAMPLE_BITS-1:0] sample;
	modport source (output valid, output kind, output sample, input ready);
	modport sink (input valid, input kind, input sample, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rwm_out_if.sv
// output channel: window result beats
`timescale 1ns / 1ps
`default_nettype none
interface rwm_out_if
	import rwm_pkg::*;
	();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] result_value;
	logic [COL_BITS-1:0]           out_col;
	logic [ROW_BITS-1:0]           out_row;
	logic                          last;
	modport source (output valid, output result_value, output out_col, output out_row,
		output last, input ready);
	modport sink (input valid, input result_value, input out_col, input out_row,
		input last, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/rwm_div.sv
// restoring divider for the window mean, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module rwm_div
	import rwm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [ACC_BITS-1:0] dividend,
	input  wire logic [CNT_BITS-1:0] divisor,
	output logic                     done,
	output logic [ACC_BITS-1:0]      quotient
);
	localparam int STEP_BITS = $clog2(ACC_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] step_q;
	logic [CNT_BITS-1:0]  rem_q;
	logic [CNT_BITS-1:0]  dsr_q;
	logic [ACC_BITS-1:0]  quo_q;
	logic [CNT_BITS:0]    trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[ACC_BITS-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_BITS'(ACC_BITS - 1);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? CNT_BITS'(trial - {1'b0, dsr_q}) : trial[CNT_BITS-1:0];
			quo_q <= {quo_q[ACC_BITS-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule
`default_nettype wire

>>> hw/rtl/rwm_ctrl.sv
// controller: sequences one input beat through store write, window scans and results
`timescale 1ns / 1ps
`default_nettype none
module rwm_ctrl
	import rwm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire status_t status,
	output cmd_t         cmd
);
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CHECK  = 4'd1;
	localparam logic [3:0] S_WSTART = 4'd2;
	localparam logic [3:0] S_SCAN   = 4'd3;
	localparam logic [3:0] S_DRAIN  = 4'd4;
	localparam logic [3:0] S_DIVS   = 4'd5;
	localparam logic [3:0] S_DIVW   = 4'd6;
	localparam logic [3:0] S_RESULT = 4'd7;
	localparam logic [3:0] S_POS    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (status.ignore) begin
					state_d = S_IDLE;
				end else begin
					cmd.setup = 1'b1;
					state_d   = status.has_out ? S_WSTART : S_POS;
				end
			end
			S_WSTART: begin
				cmd.win_init = 1'b1;
				state_d      = S_SCAN;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_last) state_d = S_DRAIN;
			end
			S_DRAIN: begin
				state_d = status.is_mean ? S_DIVS : S_RESULT;
			end
			S_DIVS: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIVW;
			end
			S_DIVW: begin
				if (status.div_done) state_d = S_RESULT;
			end
			S_RESULT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					if (status.res_last) begin
						state_d = S_POS;
					end else begin
						cmd.next_col = 1'b1;
						state_d      = S_WSTART;
					end
				end
			end
			S_POS: begin
				cmd.pos_update = 1'b1;
				state_d        = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

`ifndef SYNTHESIS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> status.out_free) else $error("result loaded into a full register");
	a_div_mean: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> status.is_mean) else $error("divider started outside mean mode");
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && status.scan_last) |=> state_q == S_DRAIN)
		else $error("window scan did not close");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/rwm_datapath.sv
// datapath: registers, frame position, line store, window accumulation and result register
`timescale 1ns / 1ps
`default_nettype none
module rwm_datapath
	import rwm_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [IDX_BITS-1:0]           cfg_index,
	input  wire logic [CFG_BITS-1:0]           cfg_data,
	input  wire logic                          in_kind,
	input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
	input  wire cmd_t                          cmd,
	output status_t                            status,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0]      out_value,
	output logic [COL_BITS-1:0]                out_col,
	output logic [ROW_BITS-1:0]                out_row,
	output logic                               out_last
);
	logic [MODE_BITS-1:0]  mode_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic [ROW_BITS-1:0]   height_q;
	logic [RAD_BITS-1:0]   radius_q;

	logic [WIDTH_BITS-1:0] w_eff;
	logic [WIDTH_BITS-1:0] w_m1;
	logic [ROW_BITS-1:0]   h_eff;
	logic [ROW_BITS-1:0]   h_m1;
	logic [RAD_BITS-1:0]   rad;

	logic [COL_BITS-1:0]     col_q;
	logic [POS_ROW_BITS-1:0] row_q;
	logic [SROW_BITS-1:0]    rmod_q;

	logic                          kind_q;
	logic signed [SAMPLE_BITS-1:0] sample_q;

	logic [COL_BITS-1:0] c_eff;
	logic                drain;
	logic                end_col;
	logic                c_ge_rad;
	logic [COL_BITS-1:0] from_col;
	logic [COL_BITS-1:0] to_col;

	logic [COL_BITS-1:0] oc_q;
	logic [COL_BITS-1:0] to_q;
	logic [ROW_BITS-1:0] orow_q;

	logic [ROW_BITS-1:0]     y0;
	logic [ROW_BITS:0]       ysum;
	logic [ROW_BITS-1:0]     y1;
	logic [COL_BITS-1:0]     x0;
	logic [COL_BITS:0]       xsum;
	logic [COL_BITS-1:0]     x1;
	logic [POS_ROW_BITS-1:0] row_gap;
	logic [SROW_BITS-1:0]    d4;
	logic [SROW_BITS-1:0]    ymod0;

	logic [ROW_BITS-1:0]  y_q;
	logic [ROW_BITS-1:0]  y1_q;
	logic [COL_BITS-1:0]  x_q;
	logic [COL_BITS-1:0]  x0_q;
	logic [COL_BITS-1:0]  x1_q;
	logic [SROW_BITS-1:0] ymod_q;
	logic                 scan_last;

	logic signed [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
	logic signed [SAMPLE_BITS-1:0] rdata_s1;
	logic                          rvalid_s1;

	logic signed [ACC_BITS-1:0]    sum_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic signed [SAMPLE_BITS-1:0] hi_q;
	logic signed [SAMPLE_BITS-1:0] lo_q;

	logic                          sum_neg;
	logic [ACC_BITS-1:0]           sum_mag;
	logic                          div_done;
	logic [ACC_BITS-1:0]           quotient;
	logic signed [SAMPLE_BITS-1:0] mean;
	logic signed [SAMPLE_BITS-1:0] result;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_value_q;
	logic [COL_BITS-1:0]           out_col_q;
	logic [ROW_BITS-1:0]           out_row_q;
	logic                          out_last_q;

	logic [WIDTH_BITS-1:0]   c_next;
	logic [POS_ROW_BITS-1:0] r_next;

	// effective register values
	always_comb begin
		if (width_q == '0) w_eff = WIDTH_BITS'(1);
		else if (width_q > WIDTH_BITS'(MAX_WIDTH)) w_eff = WIDTH_BITS'(MAX_WIDTH);
		else w_eff = width_q;
		h_eff = (height_q == '0) ? ROW_BITS'(1) : height_q;
		rad   = (radius_q > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS) : radius_q;
	end
	assign w_m1 = w_eff - 1'b1;
	assign h_m1 = h_eff - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			width_q  <= WIDTH_BITS'(1024);
			height_q <= ROW_BITS'(1024);
			radius_q <= RAD_BITS'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[MODE_BITS-1:0];
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_BITS-1:0];
				REG_HEIGHT: height_q <= cfg_data[ROW_BITS-1:0];
				REG_RADIUS: radius_q <= cfg_data[RAD_BITS-1:0];
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q   <= in_kind;
			sample_q <= in_sample;
		end
	end

	// item decode
	always_comb begin
		c_eff    = ({1'b0, col_q} >= w_eff) ? w_m1[COL_BITS-1:0] : col_q;
		drain    = row_q >= {1'b0, h_eff};
		end_col  = ({1'b0, c_eff} == w_m1);
		c_ge_rad = c_eff >= COL_BITS'(rad);
		from_col = c_ge_rad ? c_eff - COL_BITS'(rad) : '0;
		to_col   = end_col ? w_m1[COL_BITS-1:0] : c_eff - COL_BITS'(rad);
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			oc_q   <= from_col;
			to_q   <= to_col;
			orow_q <= ROW_BITS'(row_q - POS_ROW_BITS'(rad));
		end else if (cmd.next_col) begin
			oc_q <= oc_q + 1'b1;
		end
	end

	// clipped window bounds
	always_comb begin
		y0      = (orow_q >= ROW_BITS'(rad)) ? orow_q - ROW_BITS'(rad) : '0;
		ysum    = {1'b0, orow_q} + (ROW_BITS + 1)'(rad);
		y1      = (ysum > {1'b0, h_m1}) ? h_m1 : ysum[ROW_BITS-1:0];
		x0      = (oc_q >= COL_BITS'(rad)) ? oc_q - COL_BITS'(rad) : '0;
		xsum    = {1'b0, oc_q} + (COL_BITS + 1)'(rad);
		x1      = (xsum > w_m1) ? w_m1[COL_BITS-1:0] : xsum[COL_BITS-1:0];
		row_gap = row_q - {1'b0, y0};
		d4      = row_gap[SROW_BITS-1:0];
		ymod0   = (rmod_q >= d4) ? rmod_q - d4 : rmod_q + SROW_BITS'(STORE_ROWS) - d4;
	end

	assign scan_last = (y_q == y1_q) && (x_q == x1_q);

	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			y_q    <= y0;
			y1_q   <= y1;
			x_q    <= x0;
			x0_q   <= x0;
			x1_q   <= x1;
			ymod_q <= ymod0;
		end else if (cmd.scan) begin
			if (x_q == x1_q) begin
				x_q    <= x0_q;
				y_q    <= y_q + 1'b1;
				ymod_q <= (ymod_q == SROW_BITS'(STORE_ROWS - 1)) ? '0 : ymod_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end
	end

	// line store
	always_ff @(posedge clk) begin
		if (cmd.setup && !kind_q) mem[ADDR_BITS'({rmod_q, c_eff})] <= sample_q;
		if (cmd.scan) rdata_s1 <= mem[ADDR_BITS'({ymod_q, x_q})];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rvalid_s1 <= 1'b0;
		else rvalid_s1 <= cmd.scan;
	end

	// window accumulation
	always_ff @(posedge clk) begin
		if (cmd.win_init) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (rvalid_s1) begin
			sum_q <= sum_q + {{(ACC_BITS - SAMPLE_BITS){rdata_s1[SAMPLE_BITS-1]}}, rdata_s1};
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == '0 || rdata_s1 > hi_q) hi_q <= rdata_s1;
			if (cnt_q == '0 || rdata_s1 < lo_q) lo_q <= rdata_s1;
		end
	end

	assign sum_neg = sum_q[ACC_BITS-1];
	assign sum_mag = sum_neg ? ACC_BITS'(-sum_q) : ACC_BITS'(sum_q);

	rwm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_mag),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (quotient)
	);

	always_comb begin
		mean = sum_neg ? -signed'(quotient[SAMPLE_BITS-1:0]) : signed'(quotient[SAMPLE_BITS-1:0]);
		unique case (mode_q)
			MODE_MAX: result = hi_q;
			MODE_MIN: result = lo_q;
			default:  result = mean;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load_out) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_value_q <= result;
			out_col_q   <= oc_q;
			out_row_q   <= orow_q;
			out_last_q  <= (oc_q == to_q);
		end
	end

	// frame position
	assign c_next = {1'b0, c_eff} + 1'b1;
	assign r_next = row_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			rmod_q <= '0;
		end else if (cfg_we) begin
			col_q  <= '0;
			row_q  <= '0;
			rmod_q <= '0;
		end else if (cmd.pos_update) begin
			if (c_next >= w_eff) begin
				col_q <= '0;
				if (r_next >= {1'b0, h_eff} + POS_ROW_BITS'(rad)) begin
					row_q  <= '0;
					rmod_q <= '0;
				end else begin
					row_q  <= r_next;
					rmod_q <= (rmod_q == SROW_BITS'(STORE_ROWS - 1)) ? '0 : rmod_q + 1'b1;
				end
			end else begin
				col_q <= c_next[COL_BITS-1:0];
			end
		end
	end

	always_comb begin
		status.ignore    = (kind_q != drain);
		status.has_out   = (row_q >= POS_ROW_BITS'(rad)) && (end_col || c_ge_rad);
		status.scan_last = scan_last;
		status.is_mean   = (mode_q != MODE_MAX) && (mode_q != MODE_MIN);
		status.div_done  = div_done;
		status.out_free  = !out_valid_q || out_ready;
		status.res_last  = (oc_q == to_q);
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_col   = out_col_q;
	assign out_row   = out_row_q;
	assign out_last  = out_last_q;
endmodule
`default_nettype wire

>>> hw/rtl/raster_window_mean_max_min.sv
// Raster window statistic (mean, maximum or minimum over a clipped square window).
// Input channel in_ch: one beat per pixel in row order (kind 0), then after the
// frame, window_radius rows of drain beats (kind 1), one per column. A beat of
// the wrong kind for the frame phase is taken and dropped.
// Output channel out_ch: results for output pixel (out_row, out_col); last marks
// the final result caused by one input beat. A beat yields zero to radius+1 results.
// Each result scans its window from the line store, one cell per cycle on the
// single read port; the mean adds the divider's quotient loop.
// The block takes the next beat only after the current one's results are all
// loaded into the output register; one finished result may wait there while the
// next is computed, so a stalled receiver holds the block after one result.
// Configuration: cfg_we with cfg_index/cfg_data, only while idle; any write
// restarts the frame at row 0, column 0 and keeps the line store.
// Reset (arst_n low) restores default registers and frame position; the line
// store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module raster_window_mean_max_min
	import rwm_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	rwm_in_if.sink                   in_ch,
	rwm_out_if.source                out_ch,
	input  wire logic                cfg_we,
	input  wire logic [IDX_BITS-1:0] cfg_index,
	input  wire logic [CFG_BITS-1:0] cfg_data
);
	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	assign in_ch.ready = in_ready;

	rwm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	rwm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_kind   (in_ch.kind),
		.in_sample (in_ch.sample),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.out_value (out_ch.result_value),
		.out_col   (out_ch.out_col),
		.out_row   (out_ch.out_row),
		.out_last  (out_ch.last)
	);
endmodule
`default_nettype wire

>>> verif/tb_raster_window_mean_max_min.sv
// self-checking testbench for the raster window mean, max and min filter
`timescale 1ns / 1ps
`default_nettype none
module tb_raster_window_mean_max_min;
	import rwm_pkg::*;

	localparam int SETTLE      = 300;
	localparam int STALL_LEN   = 400;
	localparam int STALL_LIMIT = 20000;
	localparam int N_ITEMS     = 400;
	localparam int FRAME_CAP   = 64;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] value;
		logic [COL_BITS-1:0]           col;
		logic [ROW_BITS-1:0]           row;
		logic                          last;
	} pix_res_t;

	typedef enum {STIM_REG, STIM_BEAT} stim_op_t;

	typedef struct {
		stim_op_t op;
		int       a;
		int       b;
		bit       chk;
		int       ev;
	} stim_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0] cfg_data = '0;

	rwm_in_if in_ch ();
	rwm_out_if out_ch ();

	raster_window_mean_max_min i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// window filter state
	shortint        line_mem [STORE_DEPTH];
	int unsigned    at_col, at_row;
	logic [1:0]     f_mode;
	int unsigned    f_width, f_height, f_rad;
	pix_res_t       pending_px[$];

	int  errors = 0;
	bit  calm = 0;
	bit  stall_go = 0;
	int  stall_cnt = 0;
	int  idle_cycles = 0;

	stim_row_t dir_tab [] = '{
		'{STIM_BEAT, 0, 100, 0, 0},
		'{STIM_BEAT, 1, 0, 0, 0},
		'{STIM_REG, REG_WIDTH, 1, 0, 0},
		'{STIM_REG, REG_HEIGHT, 1, 0, 0},
		'{STIM_REG, REG_RADIUS, 0, 0, 0},
		'{STIM_REG, REG_MODE, MODE_MAX, 0, 0},
		'{STIM_BEAT, 0, 32767, 1, 32767},
		'{STIM_BEAT, 0, -32768, 1, -32768},
		'{STIM_BEAT, 1, 0, 0, 0},
		'{STIM_REG, REG_MODE, MODE_MIN, 0, 0},
		'{STIM_BEAT, 0, -1, 1, -1},
		'{STIM_REG, REG_MODE, 3, 0, 0},
		'{STIM_BEAT, 0, 12345, 1, 12345},
		'{STIM_REG, REG_WIDTH, 0, 0, 0},
		'{STIM_BEAT, 0, -7, 1, -7},
		'{STIM_REG, REG_WIDTH, 3, 0, 0},
		'{STIM_REG, REG_HEIGHT, 2, 0, 0},
		'{STIM_REG, REG_RADIUS, 1, 0, 0},
		'{STIM_REG, REG_MODE, 0, 0, 0},
		'{STIM_BEAT, 0, 32767, 0, 0},
		'{STIM_BEAT, 0, -32768, 0, 0},
		'{STIM_BEAT, 0, 32767, 0, 0},
		'{STIM_BEAT, 0, -32768, 0, 0},
		'{STIM_BEAT, 0, 1, 0, 0},
		'{STIM_BEAT, 0, -2, 0, 0},
		'{STIM_BEAT, 1, 0, 0, 0},
		'{STIM_BEAT, 1, 0, 0, 0},
		'{STIM_BEAT, 1, 0, 0, 0}
	};

	function automatic shortint window_value(int orow, int ocol, int w, int h);
		int     y0, y1, x0, x1, rad;
		longint sum, cnt;
		shortint v, hi, lo;
		begin
			rad = int'(f_rad);
			y0 = (orow - rad < 0) ? 0 : orow - rad;
			y1 = (orow + rad > h - 1) ? h - 1 : orow + rad;
			x0 = (ocol - rad < 0) ? 0 : ocol - rad;
			x1 = (ocol + rad > w - 1) ? w - 1 : ocol + rad;
			sum = 0;
			cnt = 0;
			hi = 0;
			lo = 0;
			for (int y = y0; y <= y1; y++) begin
				for (int x = x0; x <= x1; x++) begin
					v = line_mem[(y % STORE_ROWS) * MAX_WIDTH + (x % MAX_WIDTH)];
					if (cnt == 0 || v > hi) hi = v;
					if (cnt == 0 || v < lo) lo = v;
					sum += v;
					cnt++;
				end
			end
			if (f_mode == MODE_MAX) return hi;
			if (f_mode == MODE_MIN) return lo;
			if (cnt == 0) return 0;
			return shortint'(sum / cnt);
		end
	endfunction

	task automatic predict_window(input logic k, input logic signed [SAMPLE_BITS-1:0] s,
		input bit chk, input int ev);
		int unsigned w, h, rad, r, c, from, upto;
		bit          drain, row_end;
		pix_res_t    px;
		int          n;
		begin
			w = (f_width == 0) ? 1 : (f_width > MAX_WIDTH ? MAX_WIDTH : f_width);
			h = (f_height == 0) ? 1 : f_height;
			rad = f_rad;
			r = at_row;
			c = at_col;
			n = 0;
			drain = r >= h;
			if (c >= w) c = w - 1;
			if (k != drain) return;
			if (!k) line_mem[(r % STORE_ROWS) * MAX_WIDTH + (c % MAX_WIDTH)] = s;
			if (r >= rad) begin
				row_end = (c == w - 1);
				if (row_end || c >= rad) begin
					from = (c >= rad) ? c - rad : 0;
					upto = row_end ? w - 1 : c - rad;
					for (int unsigned oc = from; oc <= upto; oc++) begin
						px.value = chk ? SAMPLE_BITS'(ev)
							: window_value(int'(r - rad), int'(oc), int'(w), int'(h));
						px.col = COL_BITS'(oc);
						px.row = ROW_BITS'(r - rad);
						px.last = 0;
						pending_px = {pending_px, px};
						n++;
					end
				end
			end
			if (n > 0) pending_px[$].last = 1;
			c++;
			if (c >= w) begin
				c = 0;
				r++;
				if (r >= h + rad) r = 0;
			end
			at_col = c;
			at_row = r;
		end
	endtask

	task automatic reg_write(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
		begin
			in_ch.valid <= 0;
			if (!cfg_we) begin
				wait (pending_px.size() == 0);
				repeat (SETTLE) @(posedge clk);
			end
			cfg_we <= 1;
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
			case (idx)
				REG_MODE:   f_mode = data[1:0];
				REG_WIDTH:  f_width = data[WIDTH_BITS-1:0];
				REG_HEIGHT: f_height = data[ROW_BITS-1:0];
				REG_RADIUS: f_rad = data[RAD_BITS-1:0];
				default: ;
			endcase
			at_col = 0;
			at_row = 0;
		end
	endtask

	task automatic send_beat(input logic k, input logic signed [SAMPLE_BITS-1:0] s,
		input bit chk, input int ev);
		begin
			cfg_we <= 0;
			while (!calm && $urandom_range(99) < 37) begin
				in_ch.valid <= 0;
				@(posedge clk);
			end
			in_ch.valid <= 1;
			in_ch.kind <= k;
			in_ch.sample <= s;
			do @(posedge clk); while (!in_ch.ready);
			predict_window(k, s, chk, ev);
		end
	endtask

	// ready side with random holds and one long stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 0;
			stall_cnt <= 0;
		end else if (stall_go) begin
			stall_go <= 0;
			stall_cnt <= STALL_LEN;
			out_ch.ready <= 0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			out_ch.ready <= 0;
		end else begin
			out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
		end
	end

	always @(posedge clk) begin
		pix_res_t px;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_px.size() == 0) begin
				$error("result beat with nothing expected: col %0d row %0d", out_ch.out_col,
					out_ch.out_row);
				errors++;
			end else begin
				px = pending_px.pop_front();
				if (out_ch.result_value !== px.value) begin
					$error("result_value: expected %0d, got %0d", px.value, out_ch.result_value);
					errors++;
				end
				if (out_ch.out_col !== px.col) begin
					$error("out_col: expected %0d, got %0d", px.col, out_ch.out_col);
					errors++;
				end
				if (out_ch.out_row !== px.row) begin
					$error("out_row: expected %0d, got %0d", px.row, out_ch.out_row);
					errors++;
				end
				if (out_ch.last !== px.last) begin
					$error("last: expected %0d, got %0d", px.last, out_ch.last);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted beat or register write
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int items, frame, w, h, rad, wv, hv, beats, cut;
		in_ch.valid = 0;
		in_ch.kind = 0;
		in_ch.sample = '0;
		f_mode = 0;
		f_width = 1024;
		f_height = 1024;
		f_rad = 1;
		at_col = 0;
		at_row = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].op == STIM_REG)
				reg_write(IDX_BITS'(dir_tab[i].a), CFG_BITS'(dir_tab[i].b));
			else
				send_beat(dir_tab[i].a[0], SAMPLE_BITS'(dir_tab[i].b), dir_tab[i].chk,
					dir_tab[i].ev);
		end

		items = 0;
		frame = 0;
		while (items < N_ITEMS) begin
			wv = $urandom_range(1, 10);
			hv = $urandom_range(1, 6);
			rad = $urandom_range(0, 3);
			case (frame)
				1: begin wv = 2047; hv = 0; rad = 7; end
				3: begin wv = 1024; hv = 1; rad = 7; end
				5: begin wv = 0; hv = 65535; rad = 7; end
				default: if ($urandom_range(9) == 0) rad = 7;
			endcase
			reg_write(REG_RADIUS, CFG_BITS'(rad));
			reg_write(REG_MODE, CFG_BITS'($urandom_range(0, 3)));
			reg_write(REG_HEIGHT, CFG_BITS'(hv));
			reg_write(REG_WIDTH, CFG_BITS'(wv));
			w = (wv == 0) ? 1 : (wv > MAX_WIDTH ? MAX_WIDTH : wv);
			h = (hv == 0) ? 1 : hv;
			calm = (frame == 6 || frame == 7);
			if (frame == 2) stall_go = 1;
			beats = (h + rad) * w * ($urandom_range(3) == 0 ? 2 : 1);
			cut = ($urandom_range(6) == 0 || frame == 5) ? $urandom_range(1, 40) : beats;
			if (cut > beats) cut = beats;
			if (cut > FRAME_CAP) cut = FRAME_CAP;
			for (int b = 0; b < cut; b++) begin
				if ($urandom_range(9) == 0) begin
					send_beat(at_row < h ? 1'b1 : 1'b0, SAMPLE_BITS'($urandom), 0, 0);
					items++;
				end
				send_beat(at_row >= h, SAMPLE_BITS'($urandom), 0, 0);
				items++;
			end
			frame++;
		end
		calm = 0;

		in_ch.valid <= 0;
		cfg_we <= 0;
		wait (pending_px.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending_px.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
